// ===== sv/cie_pkg.sv =====
// cie_pkg: shared types and constants of the cbor item encoder
// opcodes, queued command and result formats, cbor head constants
// no dependencies; the front, queue, back end and top level import this package
package cie_pkg;

  // default sizes handed down from the top level
  localparam int unsigned POS_WIDTH_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [15:0] CAP_RESET       = 16'd256;

  // input opcodes
  typedef enum logic [3:0] {
    OP_UINT    = 4'd0,
    OP_SINT    = 4'd1,
    OP_TEXT    = 4'd2,
    OP_ARRAY   = 4'd3,
    OP_MAP     = 4'd4,
    OP_FLOAT   = 4'd5,
    OP_NULL    = 4'd6,
    OP_RAW     = 4'd7,
    OP_RESTART = 4'd8
  } op_e;

  // what the back end does with a queued command
  typedef enum logic [1:0] {
    K_BYTES   = 2'd0,
    K_RESTART = 2'd1,
    K_NOP     = 2'd2
  } kind_e;

  // cbor major types
  localparam logic [2:0] MT_UINT  = 3'd0;
  localparam logic [2:0] MT_NINT  = 3'd1;
  localparam logic [2:0] MT_TEXT  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;

  // additional info codes for the multi-byte head forms
  localparam logic [4:0] AI_U8  = 5'd24;
  localparam logic [4:0] AI_U16 = 5'd25;
  localparam logic [4:0] AI_U32 = 5'd26;
  localparam logic [4:0] AI_U64 = 5'd27;

  // simple values
  localparam logic [7:0] BYTE_FLOAT32 = 8'hFA;
  localparam logic [7:0] BYTE_NULL    = 8'hF6;
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

  // classified item: head byte plus left-aligned payload bytes
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  head;
    logic [3:0]  nbytes;   // payload bytes after the head: 0, 1, 2, 4 or 8
    logic        grouped;  // payload is written whole or not at all
    logic [63:0] payload;  // first payload byte in bits 63:56
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  out_byte;
    logic        last;
    logic        overflow;
    logic [15:0] written_count;
  } res_t;

endpackage

// ===== sv/cie_in_if.sv =====
// cie_in_if: input item channel of the cbor item encoder
// valid/ready handshake carrying opcode and value; no dependencies
interface cie_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [63:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ===== sv/cie_out_if.sv =====
// cie_out_if: result channel of the cbor item encoder
// valid/ready handshake carrying one emitted byte or status; no dependencies
interface cie_out_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  out_byte;
  logic        last;
  logic        overflow;
  logic [15:0] written_count;

  modport source (output valid, output has_byte, output out_byte, output last,
                  output overflow, output written_count, input ready);
  modport sink   (input valid, input has_byte, input out_byte, input last,
                  input overflow, input written_count, output ready);
endinterface

// ===== sv/cie_front.sv =====
// cie_front: accepts input items and classifies them into queued commands
// picks the head form and payload bytes; depends on cie_pkg and cie_in_if
module cie_front (
  cie_in_if.sink         item_i,
  input  logic           full_i,
  output logic           push_o,
  output cie_pkg::cmd_t  cmd_o
);
  import cie_pkg::*;

  // head byte and payload for a major type and an argument value
  function automatic cmd_t head_cmd(input logic [2:0] major, input logic [63:0] v);
    cmd_t c;
    c         = '0;
    c.kind    = K_BYTES;
    if (v < 64'd24) begin
      c.head = {major, v[4:0]};
    end else if (v[63:8] == '0) begin
      c.head    = {major, AI_U8};
      c.nbytes  = 4'd1;
      c.payload = {v[7:0], 56'd0};
    end else if (v[63:16] == '0) begin
      c.head    = {major, AI_U16};
      c.nbytes  = 4'd2;
      c.grouped = 1'b1;
      c.payload = {v[15:0], 48'd0};
    end else if (v[63:32] == '0) begin
      c.head    = {major, AI_U32};
      c.nbytes  = 4'd4;
      c.grouped = 1'b1;
      c.payload = {v[31:0], 32'd0};
    end else begin
      c.head    = {major, AI_U64};
      c.nbytes  = 4'd8;
      c.payload = v;
    end
    return c;
  endfunction

  // handshake: take an item whenever the queue has room
  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  // classification
  always_comb begin
    cmd_o = '0;
    unique case (op_e'(item_i.opcode))
      OP_UINT:  cmd_o = head_cmd(MT_UINT, item_i.value);
      OP_SINT: begin
        if (item_i.value[63]) cmd_o = head_cmd(MT_NINT, ~item_i.value);
        else                  cmd_o = head_cmd(MT_UINT, item_i.value);
      end
      OP_TEXT:  cmd_o = head_cmd(MT_TEXT, item_i.value);
      OP_ARRAY: cmd_o = head_cmd(MT_ARRAY, item_i.value);
      OP_MAP:   cmd_o = head_cmd(MT_MAP, item_i.value);
      OP_FLOAT: begin
        cmd_o.kind = K_BYTES;
        if (item_i.value[30:23] == EXP_ALL_ONES) begin
          // infinity or nan goes out as null
          cmd_o.head = BYTE_NULL;
        end else begin
          cmd_o.head    = BYTE_FLOAT32;
          cmd_o.nbytes  = 4'd4;
          cmd_o.grouped = 1'b1;
          cmd_o.payload = {item_i.value[31:0], 32'd0};
        end
      end
      OP_NULL: begin
        cmd_o.kind = K_BYTES;
        cmd_o.head = BYTE_NULL;
      end
      OP_RAW: begin
        cmd_o.kind = K_BYTES;
        cmd_o.head = item_i.value[7:0];
      end
      OP_RESTART: cmd_o.kind = K_RESTART;
      default:    cmd_o.kind = K_NOP;
    endcase
  end

endmodule

// ===== sv/cie_queue.sv =====
// cie_queue: short command queue between front and back end
// flop-based fifo of cmd_t entries; depends on cie_pkg
module cie_queue #(
  parameter int unsigned Depth = cie_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cie_pkg::cmd_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cie_pkg::cmd_t  data_o
);
  import cie_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== sv/cie_back.sv =====
// cie_back: executes queued commands, one result transaction per cycle while the
// output register is empty or being taken; holds write position and overflow
// flag, drives the output register; depends on cie_pkg and cie_out_if
module cie_back #(
  parameter int unsigned PosWidth = cie_pkg::POS_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    capacity_i,
  input  logic           valid_i,
  input  cie_pkg::cmd_t  cmd_i,
  output logic           pop_o,
  cie_out_if.source      res_o
);
  import cie_pkg::*;

  localparam int unsigned CapW = (PosWidth > 16) ? PosWidth : 16;
  localparam logic [CapW-1:0] PosMax = CapW'((64'd1 << PosWidth) - 64'd1);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic                ovf_q, ovf_d;
  logic [3:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  res_t                res_q, res_d;

  logic [CapW-1:0]     cap_ext;
  logic [PosWidth-1:0] lim;
  logic [PosWidth-1:0] grp_len;
  logic [2:0]          sel;
  logic [7:0]          cur_byte;
  logic                adv, step, ok, put, last_byte;

  // usable capacity is clipped to what the position counter can hold
  assign cap_ext = CapW'(capacity_i);
  assign lim     = PosWidth'((cap_ext < PosMax) ? cap_ext : PosMax);
  assign grp_len = PosWidth'(cmd_i.nbytes);

  // byte under the cursor: head at index 0, then payload msb first
  assign sel      = 3'(4'd8 - idx_q);
  assign cur_byte = (idx_q == '0) ? cmd_i.head : cmd_i.payload[{sel, 3'b000} +: 8];
  assign last_byte = (idx_q == cmd_i.nbytes);

  // output register advances when empty or being taken
  assign adv  = !out_valid_q || res_o.ready;
  assign step = adv && valid_i;

  // fit check for this cursor position
  always_comb begin
    if (ovf_q) begin
      ok = 1'b0;
    end else if (idx_q == '0 || !cmd_i.grouped) begin
      ok = (pos_q < lim);
    end else if (idx_q == 4'd1) begin
      ok = !(pos_q > lim) && !(grp_len > lim - pos_q);
    end else begin
      ok = 1'b1;
    end
  end

  // command execution
  always_comb begin
    pos_d = pos_q;
    ovf_d = ovf_q;
    idx_d = idx_q;
    pop_o = 1'b0;
    put   = 1'b0;
    res_d = res_q;
    if (step) begin
      res_d = '0;
      unique case (cmd_i.kind)
        K_RESTART: begin
          pos_d = '0;
          ovf_d = 1'b0;
          res_d.last = 1'b1;
          pop_o = 1'b1;
        end
        K_BYTES: begin
          if (ok) begin
            put   = 1'b1;
            pos_d = pos_q + 1'b1;
            res_d.has_byte = 1'b1;
            res_d.out_byte = cur_byte;
            res_d.last     = last_byte;
            pop_o          = last_byte;
            idx_d          = last_byte ? '0 : idx_q + 1'b1;
          end else begin
            // no room or already overflowed: item ends with a status result
            ovf_d = 1'b1;
            res_d.last = 1'b1;
            pop_o = 1'b1;
            idx_d = '0;
          end
        end
        default: begin
          res_d.last = 1'b1;
          pop_o = 1'b1;
        end
      endcase
      res_d.overflow      = ovf_d;
      res_d.written_count = 16'(pos_d);
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (step)             out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // result port
  assign res_o.valid         = out_valid_q;
  assign res_o.has_byte      = res_q.has_byte;
  assign res_o.out_byte      = res_q.out_byte;
  assign res_o.last          = res_q.last;
  assign res_o.overflow      = res_q.overflow;
  assign res_o.written_count = res_q.written_count;

`ifndef SYNTHESIS
  // every emitted byte advances the write position by one
  a_put_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && put |=> pos_q == $past(pos_q) + 1'b1)
    else $error("write position did not advance on an emitted byte");

  // overflow only clears through a restart
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && !(step && cmd_i.kind == K_RESTART) |=> ovf_q)
    else $error("overflow flag dropped without restart");

  // cursor stays within the command's bytes
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> idx_q <= cmd_i.nbytes)
    else $error("byte cursor beyond payload");

  // a status result always closes its item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.has_byte |-> res_q.last)
    else $error("status result without last");
`endif

endmodule

// ===== sv/cbor_item_encoder.sv =====
// cbor_item_encoder: top level of the cbor item encoder
// capacity register, front classifier, command queue and back end;
// depends on cie_pkg, cie_in_if, cie_out_if, cie_front, cie_queue, cie_back
//
// Usage:
//   item_i carries one cbor item per transaction (opcode, value). res_o carries
//   the encoded message one byte per transaction, most significant first,
//   plus a status transaction (has_byte 0) when an item writes nothing or
//   hits the capacity. last marks the final result of each item; overflow
//   and written_count show the message state after each result.
//   cfg_we_i/cfg_wdata_i write the capacity; write it only while idle.
// Timing:
//   an item gives 1 to 9 results (9 for a head with an 8-byte argument),
//   one per cycle from the back end while res_o.ready is high. The item
//   is registered in the queue, then its first result in the output register.
//   The front takes a new item every cycle while the queue has room.
// Reset:
//   capacity returns to 256, write position and overflow clear, queue empties.
// Backpressure:
//   when res_o.ready is low the result register holds, the back end stops,
//   and the queue fills; item_i.ready drops once the queue is full.
module cbor_item_encoder #(
  parameter int unsigned POSITION_WIDTH = cie_pkg::POS_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH    = cie_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  cie_in_if.sink      item_i,
  cie_out_if.source   res_o
);
  import cie_pkg::*;

  logic [15:0] cap_q, cap_d;
  logic        push, full, pop, q_valid;
  cmd_t        cmd_in, cmd_head;

  // capacity register
  assign cap_d = cfg_we_i ? cfg_wdata_i : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  // front: accept and classify
  cie_front u_front (
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  // queue between front and back
  cie_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cmd_head)
  );

  // back: byte sequencing and capacity tracking
  cie_back #(
    .PosWidth (POSITION_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .capacity_i (cap_q),
    .valid_i    (q_valid),
    .cmd_i      (cmd_head),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

// ===== sim/cbor_item_encoder_tb.sv =====
// cbor_item_encoder_tb: self-checking bench for the cbor item encoder
// random and directed items checked against a built-in encoder prediction;
// depends on cie_pkg, cie_in_if, cie_out_if and cbor_item_encoder
module cbor_item_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cie_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam logic [3:0]  OP_UNDEF_LO = 4'd9;
  localparam logic [3:0]  OP_UNDEF_HI = 4'd15;

  typedef struct {
    logic [3:0]  op;
    logic [63:0] value;
  } item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  cie_in_if  item_if ();
  cie_out_if res_if ();

  cbor_item_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_if),
    .res_o      (res_if)
  );

  always #10 clk_i = ~clk_i;

  // stimulus and checking state
  item_t       items_to_send[$];
  res_t        cbor_results_due[$];
  res_t        item_results[$];
  bit          item_taken;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold_cycles;
  int unsigned cycle_count;
  int unsigned errors;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned bytes_checked;
  int unsigned overflows_raised;
  int unsigned restarts_seen;

  // encoder state as the block should hold it
  logic [15:0] capacity_q;
  int unsigned write_pos_q;
  bit          overflowed_q;

  // record one result transaction with the current message state
  function automatic void add_result(bit has, logic [7:0] b);
    res_t r;
    r.has_byte      = has;
    r.out_byte      = has ? b : 8'h00;
    r.last          = 1'b0;
    r.overflow      = overflowed_q;
    r.written_count = write_pos_q[15:0];
    item_results.push_back(r);
  endfunction

  // single byte: dropped with overflow once the message is full
  function automatic void write_single(logic [7:0] b);
    if (overflowed_q) return;
    if (write_pos_q >= capacity_q) begin
      overflowed_q = 1'b1;
      return;
    end
    write_pos_q++;
    add_result(1'b1, b);
  endfunction

  // 2- or 4-byte payload, written whole or not at all
  function automatic void write_group(logic [31:0] word, int unsigned n);
    if (overflowed_q) return;
    if (write_pos_q > capacity_q || write_pos_q + n > capacity_q) begin
      overflowed_q = 1'b1;
      return;
    end
    for (int i = n; i > 0; i--) begin
      write_pos_q++;
      add_result(1'b1, 8'(word >> (8 * (i - 1))));
    end
  endfunction

  // head in the shortest form that holds the argument
  function automatic void write_head(logic [2:0] major, logic [63:0] arg);
    if (arg < 64'd24) begin
      write_single({major, arg[4:0]});
    end else if (arg <= 64'hFF) begin
      write_single({major, AI_U8});
      write_single(arg[7:0]);
    end else if (arg <= 64'hFFFF) begin
      write_single({major, AI_U16});
      write_group(arg[31:0], 2);
    end else if (arg <= 64'hFFFF_FFFF) begin
      write_single({major, AI_U32});
      write_group(arg[31:0], 4);
    end else begin
      write_single({major, AI_U64});
      for (int i = 8; i > 0; i--) write_single(8'(arg >> (8 * (i - 1))));
    end
  endfunction

  // expected results of one accepted item, appended to the due list
  function automatic void encode_item(logic [3:0] op, logic [63:0] val);
    bit was_over;
    was_over = overflowed_q;
    item_results.delete();
    case (op)
      OP_UINT:  write_head(MT_UINT, val);
      OP_SINT: begin
        if (val[63]) write_head(MT_NINT, ~val);
        else write_head(MT_UINT, val);
      end
      OP_TEXT:  write_head(MT_TEXT, val);
      OP_ARRAY: write_head(MT_ARRAY, val);
      OP_MAP:   write_head(MT_MAP, val);
      OP_FLOAT: begin
        if (val[30:23] == EXP_ALL_ONES) begin
          write_single(BYTE_NULL);
        end else begin
          write_single(BYTE_FLOAT32);
          write_group(val[31:0], 4);
        end
      end
      OP_NULL:  write_single(BYTE_NULL);
      OP_RAW:   write_single(val[7:0]);
      OP_RESTART: begin
        write_pos_q  = 0;
        overflowed_q = 1'b0;
        restarts_seen++;
      end
      default: ;
    endcase
    if (overflowed_q && !was_over) overflows_raised++;
    if (item_results.size() == 0 || (overflowed_q && !was_over)) add_result(1'b0, 8'h00);
    item_results[item_results.size() - 1].last = 1'b1;
    foreach (item_results[i]) cbor_results_due.push_back(item_results[i]);
  endfunction

  // argument spread over every head form
  function automatic logic [63:0] random_arg();
    case ($urandom_range(4))
      0:       return 64'($urandom_range(23));
      1:       return 64'($urandom_range(255, 24));
      2:       return 64'($urandom_range(16'hFFFF, 256));
      3:       return 64'($urandom_range(32'hFFFF_FFFF, 32'h1_0000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly encodable items, with restarts and undefined opcodes mixed in
  function automatic item_t random_item();
    item_t it;
    int unsigned pick;
    pick     = $urandom_range(99);
    it.value = random_arg();
    if (pick < 6) begin
      it.op = OP_RESTART;
    end else if (pick < 9) begin
      it.op = 4'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
    end else begin
      it.op = 4'($urandom_range(OP_RAW));
      if (it.op == OP_SINT && $urandom_range(1) == 1) it.value = ~it.value;
      if (it.op == OP_FLOAT || it.op == OP_RAW) it.value = {$urandom, $urandom};
      if (it.op == OP_FLOAT && $urandom_range(3) == 0) it.value[30:23] = EXP_ALL_ONES;
    end
    return it;
  endfunction

  task automatic queue_item(logic [3:0] op, logic [63:0] val);
    items_to_send.push_back('{op, val});
  endtask

  // wait until every item is sent and every result has come
  task automatic wait_idle();
    while (items_to_send.size() != 0 || item_if.valid || cbor_results_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [15:0] cap);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    capacity_q  = cap;
  endtask

  task automatic random_phase(int unsigned n, int unsigned tx_pct, int unsigned rx_pct);
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    queue_item(OP_RESTART, random_arg());
    repeat (n) items_to_send.push_back(random_item());
    wait_idle();
  endtask

  // input transaction accepted: predict its results
  always @(posedge clk_i) begin
    item_taken <= rst_ni && item_if.valid && item_if.ready;
    if (rst_ni && item_if.valid && item_if.ready) begin
      encode_item(item_if.opcode, item_if.value);
      items_accepted++;
    end
  end

  // input driver, fed from the pending item list
  always @(negedge clk_i) begin
    if (rst_ni && (!item_if.valid || item_taken)) begin
      if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item_if.valid  <= 1'b1;
        item_if.opcode <= items_to_send[0].op;
        item_if.value  <= items_to_send[0].value;
        void'(items_to_send.pop_front());
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // result receiver with random and long stalls
  always @(negedge clk_i) begin
    if (recv_hold_cycles != 0) begin
      res_if.ready <= 1'b0;
      recv_hold_cycles--;
    end else begin
      res_if.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor: compare each transaction with the oldest expectation
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.has_byte, res_if.out_byte, res_if.last, res_if.overflow,
              res_if.written_count};
      results_checked++;
      if (got.has_byte) bytes_checked++;
      if (cbor_results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result has=%0d byte=%02h last=%0d ovf=%0d count=%0d",
                 $realtime, got.has_byte, got.out_byte, got.last, got.overflow,
                 got.written_count);
      end else begin
        want = cbor_results_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected has=%0d byte=%02h last=%0d ovf=%0d count=%0d",
                   $realtime, want.has_byte, want.out_byte, want.last, want.overflow,
                   want.written_count);
          $display("%0t:          actual   has=%0d byte=%02h last=%0d ovf=%0d count=%0d",
                   $realtime, got.has_byte, got.out_byte, got.last, got.overflow,
                   got.written_count);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    item_if.valid    = 1'b0;
    item_if.opcode   = '0;
    item_if.value    = '0;
    res_if.ready     = 1'b0;
    capacity_q       = CAP_RESET;
    write_pos_q      = 0;
    overflowed_q     = 1'b0;
    send_idle_pct    = 21;
    recv_idle_pct    = 73;
    recv_hold_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every head form, negative sint, float class and opcode at the reset capacity
    queue_item(OP_RESTART, 64'h0);
    queue_item(OP_UINT, 64'd0);
    queue_item(OP_UINT, 64'd23);
    queue_item(OP_UINT, 64'd24);
    queue_item(OP_UINT, 64'hFF);
    queue_item(OP_UINT, 64'hFFFF);
    queue_item(OP_UINT, 64'hFFFF_FFFF);
    queue_item(OP_UINT, '1);
    queue_item(OP_SINT, '1);
    queue_item(OP_SINT, 64'h8000_0000_0000_0000);
    queue_item(OP_TEXT, 64'd5);
    queue_item(OP_ARRAY, 64'd300);
    queue_item(OP_MAP, 64'd70000);
    queue_item(OP_FLOAT, 64'hDEAD_BEEF_3F80_0000);
    queue_item(OP_FLOAT, 64'h7F80_0000);
    queue_item(OP_FLOAT, 64'hFFC0_0001);
    queue_item(OP_NULL, 64'h0);
    queue_item(OP_RAW, 64'hFFFF_FFFF_FFFF_FFA5);
    queue_item(OP_UNDEF_HI, '1);
    wait_idle();

    // exact fill, single byte overflow, sticky flag, group overflow
    write_capacity(16'd10);
    queue_item(OP_RESTART, 64'h0);
    queue_item(OP_UINT, 64'h1_0000);
    queue_item(OP_FLOAT, 64'h4049_0FDB);
    queue_item(OP_RAW, 64'h5A);
    queue_item(OP_NULL, 64'h0);
    queue_item(OP_RESTART, 64'h0);
    queue_item(OP_MAP, 64'h1234);
    queue_item(OP_FLOAT, 64'hC2F6_E979);
    queue_item(OP_UINT, 64'd300);
    queue_item(OP_RESTART, 64'h0);
    queue_item(OP_UINT, 64'h1_0000_0000);
    wait_idle();

    // capacity lowered below the current position, then zero capacity
    write_capacity(16'd3);
    queue_item(OP_RAW, 64'h3C);
    wait_idle();
    write_capacity(16'd0);
    queue_item(OP_RESTART, 64'h0);
    queue_item(OP_NULL, 64'h0);
    wait_idle();

    // random items under the three idling schemes
    write_capacity(16'($urandom_range(48, 8)));
    random_phase(40, 21, 73);
    write_capacity(16'hFFFF);
    random_phase(40, 73, 21);
    write_capacity(16'($urandom_range(64, 1)));
    recv_hold_cycles = 300;
    random_phase(40, 0, 0);

    $display("checked %0d results (%0d bytes) from %0d items", results_checked,
             bytes_checked, items_accepted);
    $display("overflows raised %0d times over %0d restarts, capacities 0 to 65535",
             overflows_raised, restarts_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cie_pkg.sv
sv/cie_in_if.sv
sv/cie_out_if.sv
sv/cie_front.sv
sv/cie_queue.sv
sv/cie_back.sv
sv/cbor_item_encoder.sv
sim/cbor_item_encoder_tb.sv
